// ===== src/calendar_day_difference_defines.svh =====
// Assertion macros for the calendar day difference block.
// Included by the top level; no other dependencies.
`ifndef CALENDAR_DAY_DIFFERENCE_DEFINES_SVH
`define CALENDAR_DAY_DIFFERENCE_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define CDD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("calendar_day_difference: same-cycle check failed");
// Antecedent implies consequent in the next cycle.
`define CDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("calendar_day_difference: next-cycle check failed");
`else
`define CDD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/cdd_pkg.sv =====
// Shared widths, constants, command struct and calendar tables.
// Used by cdd_ctrl, cdd_dp and calendar_day_difference.
package cdd_pkg;
	localparam int YearW   = 14;
	localparam int MonW    = 4;
	localparam int DayW    = 5;
	localparam int CountW  = 22;
	localparam int DayNumW = 23;
	localparam int QuotW   = 8;
	localparam int RemW    = 7;

	// floor(y / 100) = (y * 5243) >> 19, exact for y below 16384
	localparam int RecipW     = 13;
	localparam int RecipShift = 19;
	localparam logic [RecipW-1:0] Recip100 = 13'd5243;

	localparam logic [MonW-1:0] MonJan = 4'd1;
	localparam logic [MonW-1:0] MonFeb = 4'd2;
	localparam logic [MonW-1:0] MonApr = 4'd4;
	localparam logic [MonW-1:0] MonJun = 4'd6;
	localparam logic [MonW-1:0] MonSep = 4'd9;
	localparam logic [MonW-1:0] MonNov = 4'd11;
	localparam logic [MonW-1:0] MonDec = 4'd12;

	typedef struct packed {
		logic load;     // capture the input fields
		logic div_en;   // quotient of year by 100
		logic rem_en;   // remainder and leap flag
		logic base_en;  // day number of January 1 and day clamp
		logic sum_en;   // full day number of the date
		logic sel_end;  // work on the end date
		logic finish;   // difference, saturate, strobe out
	} cdd_cmd_t;

	function automatic logic [MonW-1:0] clamp_month(input logic [MonW-1:0] m);
		logic [MonW-1:0] r;
		r = m;
		if (m < MonJan) r = MonJan;
		if (m > MonDec) r = MonDec;
		return r;
	endfunction

	function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic leap);
		logic [DayW-1:0] r;
		r = 5'd31;
		if (m == MonFeb) r = leap ? 5'd29 : 5'd28;
		else if (m == MonApr || m == MonJun || m == MonSep || m == MonNov) r = 5'd30;
		return r;
	endfunction

	function automatic logic [8:0] days_before(input logic [MonW-1:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction
endpackage

// ===== src/calendar_day_difference.sv =====
// Top level of the Gregorian day difference block.
// Instantiates cdd_ctrl and cdd_dp; uses cdd_pkg and the assertion macros header.
//
// Usage:
//   Present a start date and an end date on the input ports and raise start
//   while busy is low; that edge transfers the item. Fields out of range are
//   clamped (month to 1..12, day to 1..length of its month).
//   The result appears on day_count with done high for exactly one cycle,
//   after the sequencer's output step. day_count is zero when the end
//   is not after the start, and saturates at its all-ones value.
//   Each date's day number takes four sequencer steps (reciprocal divide by
//   100, remainder and leap test, January 1 day number, month and day add),
//   run for start and end in turn, plus one step for the difference;
//   start is ignored while busy is high.
//   done goes high in the same cycle busy drops, so a new start may be
//   given right there.
//   The receiver cannot stall: it must take the result in the done cycle.
//   Reset clears the sequencer and the strobe; no result is pending after it.
`include "calendar_day_difference_defines.svh"

module calendar_day_difference (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [cdd_pkg::YearW-1:0]  start_year,
	input  logic [cdd_pkg::MonW-1:0]   start_month,
	input  logic [cdd_pkg::DayW-1:0]   start_day,
	input  logic [cdd_pkg::YearW-1:0]  end_year,
	input  logic [cdd_pkg::MonW-1:0]   end_month,
	input  logic [cdd_pkg::DayW-1:0]   end_day,
	output logic [cdd_pkg::CountW-1:0] day_count,
	output logic                       done
);
	cdd_pkg::cdd_cmd_t cmd;

	cdd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd)
	);

	cdd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.start_year (start_year),
		.start_month(start_month),
		.start_day  (start_day),
		.end_year   (end_year),
		.end_month  (end_month),
		.end_day    (end_day),
		.day_count  (day_count),
		.done       (done)
	);

	`CDD_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`CDD_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`CDD_ASSERT_NEXT(a_finish_done, clk, arst_n, cmd.finish, done)
	`CDD_ASSERT_SAME(a_load_idle, clk, arst_n, cmd.load, start && !busy)
endmodule

// ===== src/cdd_ctrl.sv =====
// Sequencer for the day difference: steps the datapath through both dates.
// Depends on cdd_pkg for the command struct.
module cdd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output cdd_pkg::cdd_cmd_t cmd
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StDiv  = 3'd1;
	localparam logic [2:0] StRem  = 3'd2;
	localparam logic [2:0] StBase = 3'd3;
	localparam logic [2:0] StSum  = 3'd4;
	localparam logic [2:0] StOut  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       sel_end_q, sel_end_d;

	always_comb begin
		state_d   = state_q;
		sel_end_d = sel_end_q;
		cmd       = '0;
		cmd.sel_end = sel_end_q;
		case (state_q)
			StIdle: begin
				if (start) begin
					cmd.load  = 1'b1;
					sel_end_d = 1'b0;
					state_d   = StDiv;
				end
			end
			StDiv: begin
				cmd.div_en = 1'b1;
				state_d    = StRem;
			end
			StRem: begin
				cmd.rem_en = 1'b1;
				state_d    = StBase;
			end
			StBase: begin
				cmd.base_en = 1'b1;
				state_d     = StSum;
			end
			StSum: begin
				cmd.sum_en = 1'b1;
				// second pass covers the end date
				if (sel_end_q) begin
					state_d = StOut;
				end else begin
					sel_end_d = 1'b1;
					state_d   = StDiv;
				end
			end
			StOut: begin
				cmd.finish = 1'b1;
				state_d    = StIdle;
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			sel_end_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			sel_end_q <= sel_end_d;
		end
	end

	assign busy = (state_q != StIdle);
endmodule

// ===== src/cdd_dp.sv =====
// Datapath: captures both dates, forms each day number in four steps,
// then the saturated difference. Depends on cdd_pkg.
module cdd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cdd_pkg::cdd_cmd_t               cmd,
	input  logic [cdd_pkg::YearW-1:0]       start_year,
	input  logic [cdd_pkg::MonW-1:0]        start_month,
	input  logic [cdd_pkg::DayW-1:0]        start_day,
	input  logic [cdd_pkg::YearW-1:0]       end_year,
	input  logic [cdd_pkg::MonW-1:0]        end_month,
	input  logic [cdd_pkg::DayW-1:0]        end_day,
	output logic [cdd_pkg::CountW-1:0]      day_count,
	output logic                            done
);
	localparam int ProdW = cdd_pkg::YearW + cdd_pkg::RecipW;

	logic [cdd_pkg::YearW-1:0]   sy_q, ey_q;
	logic [cdd_pkg::MonW-1:0]    sm_q, em_q;
	logic [cdd_pkg::DayW-1:0]    sd_q, ed_q;
	logic [cdd_pkg::QuotW-1:0]   q_q;
	logic [cdd_pkg::RemW-1:0]    r_q;
	logic                        leap_q;
	logic [cdd_pkg::DayNumW-1:0] base_q, s_q, e_q;
	logic [cdd_pkg::DayW-1:0]    day_q;
	logic [cdd_pkg::CountW-1:0]  count_q;
	logic                        done_q;

	logic [cdd_pkg::YearW-1:0]   y;
	logic [cdd_pkg::MonW-1:0]    m;
	logic [cdd_pkg::DayW-1:0]    d, d_lo, len;
	logic [ProdW-1:0]            prod;
	logic [cdd_pkg::YearW:0]     hundreds, rem_full, y_plus3;
	logic [cdd_pkg::RemW-1:0]    rem;
	logic                        leap;
	logic [cdd_pkg::QuotW:0]     ceil100;
	logic [cdd_pkg::QuotW-2:0]   ceil400;
	logic [cdd_pkg::DayNumW-1:0] base, num, diff;

	// pick the date of the current pass
	assign y = cmd.sel_end ? ey_q : sy_q;
	assign m = cdd_pkg::clamp_month(cmd.sel_end ? em_q : sm_q);
	assign d = cmd.sel_end ? ed_q : sd_q;

	assign prod = ProdW'(y) * ProdW'(cdd_pkg::Recip100);

	assign hundreds = (cdd_pkg::YearW+1)'(q_q) * (cdd_pkg::YearW+1)'(100);
	assign rem_full = {1'b0, y} - hundreds;
	assign rem      = rem_full[cdd_pkg::RemW-1:0];
	assign leap     = (y[1:0] == 2'b00) && ((rem != '0) || (q_q[1:0] == 2'b00));

	// leap years strictly before y, year 0 included
	assign y_plus3 = {1'b0, y} + (cdd_pkg::YearW+1)'(3);
	assign ceil100 = {1'b0, q_q} + (cdd_pkg::QuotW+1)'(r_q != '0);
	assign ceil400 = (cdd_pkg::QuotW-1)'(q_q[cdd_pkg::QuotW-1:2])
		+ (cdd_pkg::QuotW-1)'((q_q[1:0] != 2'b00) || (r_q != '0));
	assign base = cdd_pkg::DayNumW'(y) * cdd_pkg::DayNumW'(365)
		+ cdd_pkg::DayNumW'(y_plus3[cdd_pkg::YearW:2])
		- cdd_pkg::DayNumW'(ceil100)
		+ cdd_pkg::DayNumW'(ceil400);

	assign d_lo = (d == '0) ? cdd_pkg::DayW'(1) : d;
	assign len  = cdd_pkg::month_len(m, leap_q);

	assign num = base_q + cdd_pkg::DayNumW'(cdd_pkg::days_before(m))
		+ cdd_pkg::DayNumW'((m > cdd_pkg::MonFeb) && leap_q)
		+ cdd_pkg::DayNumW'(day_q) - cdd_pkg::DayNumW'(1);

	assign diff = (e_q > s_q) ? (e_q - s_q) : '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sy_q <= start_year;
			sm_q <= start_month;
			sd_q <= start_day;
			ey_q <= end_year;
			em_q <= end_month;
			ed_q <= end_day;
		end
		if (cmd.div_en) q_q <= prod[cdd_pkg::RecipShift +: cdd_pkg::QuotW];
		if (cmd.rem_en) begin
			r_q    <= rem;
			leap_q <= leap;
		end
		if (cmd.base_en) begin
			base_q <= base;
			day_q  <= (d_lo > len) ? len : d_lo;
		end
		if (cmd.sum_en) begin
			if (cmd.sel_end) e_q <= num;
			else s_q <= num;
		end
		// saturate spans beyond the output range
		if (cmd.finish) begin
			count_q <= diff[cdd_pkg::DayNumW-1] ? '1 : diff[cdd_pkg::CountW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign day_count = count_q;
	assign done      = done_q;
endmodule

// ===== test/tb_calendar_day_difference.sv =====
// Self-checking testbench for calendar_day_difference: directed date pairs, then random ones.
// Predicts day counts from its own Gregorian day numbering or typed-in answers; depends on cdd_pkg and the RTL.
module tb_calendar_day_difference;
	localparam int unsigned CountMax   = (1 << cdd_pkg::CountW) - 1;
	localparam int          DateW      = cdd_pkg::YearW + cdd_pkg::MonW + cdd_pkg::DayW;
	localparam int          RandItems  = 600;
	localparam int          CycleLimit = 200000;

	typedef struct packed {
		logic [cdd_pkg::YearW-1:0]  sy;
		logic [cdd_pkg::MonW-1:0]   sm;
		logic [cdd_pkg::DayW-1:0]   sd;
		logic [cdd_pkg::YearW-1:0]  ey;
		logic [cdd_pkg::MonW-1:0]   em;
		logic [cdd_pkg::DayW-1:0]   ed;
		logic                       known;
		logic [cdd_pkg::CountW-1:0] want;
	} date_pair_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic [cdd_pkg::YearW-1:0]  start_year = '0;
	logic [cdd_pkg::MonW-1:0]   start_month = cdd_pkg::MonJan;
	logic [cdd_pkg::DayW-1:0]   start_day = 5'd1;
	logic [cdd_pkg::YearW-1:0]  end_year = '0;
	logic [cdd_pkg::MonW-1:0]   end_month = cdd_pkg::MonJan;
	logic [cdd_pkg::DayW-1:0]   end_day = 5'd1;
	logic [cdd_pkg::CountW-1:0] day_count;
	logic                       done;

	// typed-in answer for the pair on the ports, if any
	logic                       pinned_known = 1'b0;
	logic [cdd_pkg::CountW-1:0] pinned_count = '0;

	logic [cdd_pkg::CountW-1:0] pending_counts[$];
	logic [cdd_pkg::CountW-1:0] want_count;
	date_pair_t                 directed_pairs[$];
	int                         errors = 0;
	int                         cycles = 0;

	calendar_day_difference u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.start_year (start_year),
		.start_month(start_month),
		.start_day  (start_day),
		.end_year   (end_year),
		.end_month  (end_month),
		.end_day    (end_day),
		.day_count  (day_count),
		.done       (done)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic bit leap_year(input int unsigned yy);
		return (yy % 4 == 0) && ((yy % 100 != 0) || (yy % 400 == 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned yy, input int unsigned mm);
		if (mm == cdd_pkg::MonFeb)
			return leap_year(yy) ? 29 : 28;
		if (mm == cdd_pkg::MonApr || mm == cdd_pkg::MonJun
				|| mm == cdd_pkg::MonSep || mm == cdd_pkg::MonNov)
			return 30;
		return 31;
	endfunction

	// days since the first of January of year 0, fields clamped first
	function automatic int unsigned day_index(input logic [cdd_pkg::YearW-1:0] y,
			input logic [cdd_pkg::MonW-1:0] m, input logic [cdd_pkg::DayW-1:0] d);
		int unsigned yy, mm, dd, lim, total;
		yy = y;
		mm = m;
		dd = d;
		if (mm < cdd_pkg::MonJan) mm = cdd_pkg::MonJan;
		if (mm > cdd_pkg::MonDec) mm = cdd_pkg::MonDec;
		lim = month_days(yy, mm);
		if (dd < 1) dd = 1;
		if (dd > lim) dd = lim;
		// year 0 is leap, so count leap years among 0 .. yy-1
		total = 365 * yy + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
		for (int k = 1; k < mm; k++)
			total += month_days(yy, k);
		return total + dd - 1;
	endfunction

	function automatic logic [cdd_pkg::CountW-1:0] days_between(
			input logic [cdd_pkg::YearW-1:0] sy, input logic [cdd_pkg::MonW-1:0] sm,
			input logic [cdd_pkg::DayW-1:0] sd, input logic [cdd_pkg::YearW-1:0] ey,
			input logic [cdd_pkg::MonW-1:0] em, input logic [cdd_pkg::DayW-1:0] ed);
		int unsigned s, e, diff;
		s = day_index(sy, sm, sd);
		e = day_index(ey, em, ed);
		diff = (e > s) ? e - s : 0;
		if (diff > CountMax) diff = CountMax;
		return diff[cdd_pkg::CountW-1:0];
	endfunction

	function automatic date_pair_t pair(input int sy, input int sm, input int sd,
			input int ey, input int em, input int ed, input bit known, input int want);
		date_pair_t p;
		p.sy = cdd_pkg::YearW'(sy);
		p.sm = cdd_pkg::MonW'(sm);
		p.sd = cdd_pkg::DayW'(sd);
		p.ey = cdd_pkg::YearW'(ey);
		p.em = cdd_pkg::MonW'(em);
		p.ed = cdd_pkg::DayW'(ed);
		p.known = known;
		p.want = cdd_pkg::CountW'(want);
		return p;
	endfunction

	// present one pair and hold it until the block takes it
	task automatic send_pair(input date_pair_t p);
		@(negedge clk);
		start        <= 1'b1;
		start_year   <= p.sy;
		start_month  <= p.sm;
		start_day    <= p.sd;
		end_year     <= p.ey;
		end_month    <= p.em;
		end_day      <= p.ed;
		pinned_known <= p.known;
		pinned_count <= p.want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// drop start for a burst; optionally let the block go idle first
	task automatic pause_sender(input int burst, input bit after_busy);
		@(negedge clk);
		start <= 1'b0;
		if (after_busy)
			while (busy !== 1'b0) @(negedge clk);
		repeat (burst - 1) @(negedge clk);
	endtask

	function automatic date_pair_t random_pair();
		date_pair_t p;
		int unsigned kind;
		kind = $urandom_range(0, 9);
		p = pair(0, 1, 1, 0, 1, 1, 1'b0, 0);
		if (kind <= 5) begin
			// months in range, days 1..31, end year at most three years after start year
			p.sy = cdd_pkg::YearW'(($urandom_range(0, 3) == 0)
				? $urandom_range(0, 25) * 400 + $urandom_range(0, 3) * 100
				: $urandom_range(0, 9995));
			p.sm = cdd_pkg::MonW'($urandom_range(1, 12));
			p.sd = cdd_pkg::DayW'($urandom_range(1, 31));
			p.ey = cdd_pkg::YearW'(p.sy + $urandom_range(0, 3));
			p.em = cdd_pkg::MonW'($urandom_range(1, 12));
			p.ed = cdd_pkg::DayW'($urandom_range(1, 31));
		end else if (kind <= 7) begin
			{p.sy, p.sm, p.sd} = DateW'($urandom);
			{p.ey, p.em, p.ed} = DateW'($urandom);
		end else if (kind == 8) begin
			// start year and month at or above the end's; random days, so end mostly on or before start
			p.ey = cdd_pkg::YearW'($urandom_range(0, 9999));
			p.em = cdd_pkg::MonW'($urandom_range(0, 15));
			p.ed = cdd_pkg::DayW'($urandom_range(0, 31));
			p.sy = cdd_pkg::YearW'(p.ey + $urandom_range(0, 1));
			p.sm = cdd_pkg::MonW'($urandom_range(p.em, 15));
			p.sd = cdd_pkg::DayW'($urandom_range(0, 31));
		end else begin
			p.sy = cdd_pkg::YearW'($urandom_range(0, 16383));
			p.sm = cdd_pkg::MonW'($urandom_range(0, 15));
			p.sd = cdd_pkg::DayW'($urandom_range(0, 31));
			p.ey = cdd_pkg::YearW'($urandom_range(9999, 16383));
			p.em = cdd_pkg::MonW'($urandom_range(0, 15));
			p.ed = cdd_pkg::DayW'($urandom_range(0, 31));
		end
		return p;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_counts.size() == 0) begin
					$error("day_count: no result expected, actual %0d", day_count);
					errors++;
				end else begin
					want_count = pending_counts.pop_front();
					if (day_count !== want_count) begin
						$error("day_count: expected %0d, actual %0d", want_count, day_count);
						errors++;
					end
				end
			end
			if (start && !busy)
				pending_counts.push_back(pinned_known ? pinned_count
					: days_between(start_year, start_month, start_day,
						end_year, end_month, end_day));
		end
	end

	initial begin
		date_pair_t p;
		bit idling;

		directed_pairs.push_back(pair(2024, 3, 15, 2024, 3, 15, 1, 0));
		directed_pairs.push_back(pair(2024, 3, 16, 2024, 3, 15, 1, 0));
		directed_pairs.push_back(pair(0, 1, 1, 9999, 12, 31, 1, 3652424));
		directed_pairs.push_back(pair(0, 1, 1, 16383, 12, 31, 1, CountMax));
		directed_pairs.push_back(pair(9999, 12, 31, 0, 1, 1, 1, 0));
		directed_pairs.push_back(pair(2023, 12, 31, 2024, 1, 1, 1, 1));
		directed_pairs.push_back(pair(2024, 2, 28, 2024, 3, 1, 1, 2));
		directed_pairs.push_back(pair(1900, 2, 28, 1900, 3, 1, 1, 1));
		directed_pairs.push_back(pair(2000, 2, 28, 2000, 3, 1, 1, 2));
		directed_pairs.push_back(pair(0, 2, 28, 0, 3, 1, 1, 2));
		directed_pairs.push_back(pair(2020, 0, 5, 2020, 1, 10, 1, 5));
		directed_pairs.push_back(pair(2020, 15, 1, 2021, 1, 1, 1, 31));
		directed_pairs.push_back(pair(2019, 13, 31, 2020, 14, 0, 0, 0));
		directed_pairs.push_back(pair(2020, 5, 0, 2020, 5, 1, 1, 0));
		directed_pairs.push_back(pair(2021, 4, 31, 2021, 5, 1, 1, 1));
		directed_pairs.push_back(pair(2024, 2, 31, 2024, 3, 1, 1, 1));
		directed_pairs.push_back(pair(2023, 2, 30, 2023, 3, 1, 1, 1));
		directed_pairs.push_back(pair(0, 0, 0, 0, 1, 1, 1, 0));
		directed_pairs.push_back(pair(12000, 6, 15, 16383, 1, 1, 0, 0));
		directed_pairs.push_back(pair(16383, 15, 31, 16383, 15, 31, 1, 0));
		directed_pairs.push_back(pair(1999, 12, 31, 2000, 12, 31, 1, 366));
		directed_pairs.push_back(pair(2100, 1, 1, 2101, 1, 1, 1, 365));
		directed_pairs.push_back(pair(0, 1, 1, 11483, 6, 1, 0, 0));
		directed_pairs.push_back(pair(1, 1, 1, 11484, 1, 1, 0, 0));
		directed_pairs.push_back(pair(10000, 10, 20, 5000, 7, 9, 1, 0));

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_pairs[i])
			send_pair(directed_pairs[i]);

		for (int i = 0; i < RandItems; i++) begin
			// idle in stretches, with quiet stretches between and none at the end
			idling = (i < RandItems - 150) && ((i / 40) % 3 != 2);
			if (idling && $urandom_range(0, 2) == 0)
				pause_sender($urandom_range(1, 4), $urandom_range(0, 1));
			p = random_pair();
			send_pair(p);
		end
		@(negedge clk);
		start <= 1'b0;

		while (pending_counts.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
